/* rtl/core/tdrs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdrs_pkg
// shared types and constants of the tank drain and refill sequencer
// ----------------------------------------------------------------------------
package tdrs_pkg;

  localparam int unsigned DrainSecW      = 16;
  localparam int unsigned TickW          = 10;
  localparam int unsigned LevelW         = 2;
  localparam int unsigned PhaseW         = 3;
  localparam int unsigned CfgIdxW        = 1;
  localparam int unsigned CfgDataW       = 16;
  localparam int unsigned SecondCountW   = 16;

  localparam logic [DrainSecW-1:0] DrainSecReset = DrainSecW'(30);
  localparam logic [TickW-1:0]     TicksPerSecReset = TickW'(10);

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgDrainSeconds   = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgTicksPerSecond = 1'b1;

  // request codes
  localparam logic ReqTick  = 1'b0;
  localparam logic ReqStart = 1'b1;

  // level codes
  localparam logic [LevelW-1:0] LevelLow  = 2'd0;
  localparam logic [LevelW-1:0] LevelHigh = 2'd2;

  typedef enum logic [PhaseW-1:0] {
    PH_IDLE         = 3'd0,
    PH_DRAIN_SETTLE = 3'd1,
    PH_WAIT_LOW     = 3'd2,
    PH_DRAIN_HOLD   = 3'd3,
    PH_FILL_SETTLE  = 3'd4,
    PH_WAIT_HIGH    = 3'd5,
    PH_ABORTED      = 3'd6
  } phase_e;

  typedef struct packed {
    phase_e phase;
    logic   drain_on;
    logic   fill_on;
    logic   running;
  } ctrl_t;

endpackage

/* rtl/core/tdrs_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdrs_step
// next-state logic for one beat: phase, valves and the tick/second counters
// ----------------------------------------------------------------------------
module tdrs_step #(
  parameter int unsigned SecW = tdrs_pkg::SecondCountW
) (
  input  tdrs_pkg::ctrl_t                  ctrl_i,
  input  logic [tdrs_pkg::TickW-1:0]       tick_i,
  input  logic [SecW-1:0]                  sec_i,
  input  logic [tdrs_pkg::DrainSecW-1:0]   drain_seconds_i,
  input  logic [tdrs_pkg::TickW-1:0]       ticks_per_second_i,
  input  logic                             req_type_i,
  input  logic [tdrs_pkg::LevelW-1:0]      level_i,
  input  logic                             fault_i,
  output tdrs_pkg::ctrl_t                  ctrl_o,
  output logic [tdrs_pkg::TickW-1:0]       tick_o,
  output logic [SecW-1:0]                  sec_o,
  output logic                             done_o
);
  import tdrs_pkg::*;

  localparam int unsigned CmpW = (SecW > DrainSecW) ? SecW : DrainSecW;

  logic             active;
  logic [TickW-1:0] tick_inc;
  logic             elapsed;
  logic [SecW-1:0]  sec_hold;
  logic             hold_over;

  assign active = (ctrl_i.phase != PH_IDLE) && (ctrl_i.phase != PH_ABORTED);

  // a second is over when the wrapped count reaches the setting (zero means every tick)
  assign tick_inc = tick_i + TickW'(1);
  assign elapsed  = (tick_inc >= ticks_per_second_i) || (tick_inc == '0);

  // saturating second count during the hold
  assign sec_hold  = (elapsed && (sec_i != '1)) ? sec_i + SecW'(1) : sec_i;
  assign hold_over = (CmpW'(sec_hold) >= CmpW'(drain_seconds_i)) || (sec_hold == '1);

  always_comb begin
    ctrl_o = ctrl_i;
    tick_o = tick_i;
    sec_o  = sec_i;
    done_o = 1'b0;
    if (active && fault_i) begin
      ctrl_o.phase = PH_ABORTED;
    end else if (req_type_i == ReqStart) begin
      if (!ctrl_i.running && !fault_i) begin
        ctrl_o.running  = 1'b1;
        ctrl_o.drain_on = 1'b1;
        ctrl_o.fill_on  = 1'b0;
        ctrl_o.phase    = PH_DRAIN_SETTLE;
        tick_o          = '0;
        sec_o           = '0;
      end
    end else if (active) begin
      unique case (ctrl_i.phase)
        PH_DRAIN_SETTLE, PH_FILL_SETTLE: begin
          tick_o = elapsed ? '0 : tick_inc;
          if (elapsed) begin
            ctrl_o.phase = (ctrl_i.phase == PH_DRAIN_SETTLE) ? PH_WAIT_LOW : PH_WAIT_HIGH;
          end
        end
        PH_WAIT_LOW: begin
          if (level_i == LevelLow) begin
            tick_o = '0;
            sec_o  = '0;
            if (drain_seconds_i == '0) begin
              ctrl_o.drain_on = 1'b0;
              ctrl_o.fill_on  = 1'b1;
              ctrl_o.phase    = PH_FILL_SETTLE;
            end else begin
              ctrl_o.phase = PH_DRAIN_HOLD;
            end
          end
        end
        PH_DRAIN_HOLD: begin
          tick_o = elapsed ? '0 : tick_inc;
          sec_o  = sec_hold;
          if (hold_over) begin
            ctrl_o.drain_on = 1'b0;
            ctrl_o.fill_on  = 1'b1;
            ctrl_o.phase    = PH_FILL_SETTLE;
            tick_o          = '0;
            sec_o           = '0;
          end
        end
        PH_WAIT_HIGH: begin
          if (level_i == LevelHigh) begin
            ctrl_o.fill_on = 1'b0;
            ctrl_o.running = 1'b0;
            ctrl_o.phase   = PH_IDLE;
            tick_o         = '0;
            sec_o          = '0;
            done_o         = 1'b1;
          end
        end
        default: begin
          ctrl_o = ctrl_i;
        end
      endcase
    end
  end

endmodule

/* rtl/core/tank_drain_refill_sequencer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tank_drain_refill_sequencer
// drain, hold, refill sequencing of one tank from start commands and ticks
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+----------------------------------------
//  request  | in_valid_i / in_ready_o   | req_type_i, level_i, fault_i
//  result   | out_valid_o / out_ready_i | drain_valve_o, fill_valve_o,
//           |                           | busy_res_o, phase_o, done_res_o
//  config   | cfg_we_i (no wait)        | cfg_idx_i, cfg_data_i
//
//  sequencer state updates at the accepting edge
//  and the result lands in the output register on the same edge
//  one result beat per request beat
//  in_ready_o is high while the output register is empty or being emptied,
//  so a stalled output holds at most one result and then back-pressures
//  reset leaves the sequencer idle, valves closed, settings at defaults
// ----------------------------------------------------------------------------
module tank_drain_refill_sequencer #(
  parameter int unsigned SECOND_COUNT_WIDTH = tdrs_pkg::SecondCountW
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // request channel
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             req_type_i,
  input  logic [tdrs_pkg::LevelW-1:0]      level_i,
  input  logic                             fault_i,
  // result channel
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             drain_valve_o,
  output logic                             fill_valve_o,
  output logic                             busy_res_o,
  output logic [tdrs_pkg::PhaseW-1:0]      phase_o,
  output logic                             done_res_o,
  // configuration port
  input  logic                             cfg_we_i,
  input  logic [tdrs_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [tdrs_pkg::CfgDataW-1:0]    cfg_data_i
);
  import tdrs_pkg::*;

  // settings
  logic [DrainSecW-1:0] drain_seconds_q;
  logic [TickW-1:0]     ticks_per_second_q;

  // sequencer state
  ctrl_t                         ctrl_q, ctrl_d;
  logic [TickW-1:0]              tick_q, tick_d;
  logic [SECOND_COUNT_WIDTH-1:0] sec_q, sec_d;
  logic                          done_d;

  // output register
  logic          out_valid_q;
  ctrl_t         res_ctrl_q;
  logic          res_done_q;

  logic in_fire;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // configuration writes take effect at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drain_seconds_q    <= DrainSecReset;
      ticks_per_second_q <= TicksPerSecReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgDrainSeconds:   drain_seconds_q    <= cfg_data_i[DrainSecW-1:0];
        CfgTicksPerSecond: ticks_per_second_q <= cfg_data_i[TickW-1:0];
        default:           drain_seconds_q    <= drain_seconds_q;
      endcase
    end
  end

  // next state for the beat being accepted
  tdrs_step #(
    .SecW (SECOND_COUNT_WIDTH)
  ) u_step (
    .ctrl_i             (ctrl_q),
    .tick_i             (tick_q),
    .sec_i              (sec_q),
    .drain_seconds_i    (drain_seconds_q),
    .ticks_per_second_i (ticks_per_second_q),
    .req_type_i         (req_type_i),
    .level_i            (level_i),
    .fault_i            (fault_i),
    .ctrl_o             (ctrl_d),
    .tick_o             (tick_d),
    .sec_o              (sec_d),
    .done_o             (done_d)
  );

  // sequencer state only moves on an accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '{phase: PH_IDLE, drain_on: 1'b0, fill_on: 1'b0, running: 1'b0};
      tick_q <= '0;
      sec_q  <= '0;
    end else if (in_fire) begin
      ctrl_q <= ctrl_d;
      tick_q <= tick_d;
      sec_q  <= sec_d;
    end
  end

  // output register: loaded with the post-beat state, held while stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_ctrl_q <= ctrl_d;
      res_done_q <= done_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign drain_valve_o = res_ctrl_q.drain_on;
  assign fill_valve_o  = res_ctrl_q.fill_on;
  assign busy_res_o    = res_ctrl_q.running;
  assign phase_o       = res_ctrl_q.phase;
  assign done_res_o    = res_done_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------

  // the two valves are never driven open together
  a_valves_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl_q.drain_on && ctrl_q.fill_on))
    else $error("drain and fill valves open together");

  // an abort is final until reset
  a_abort_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_q.phase == PH_ABORTED) |=> (ctrl_q.phase == PH_ABORTED))
    else $error("sequencer left the aborted phase");

  // idle means not running, and any other phase means running
  a_idle_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_q.phase == PH_IDLE) == !ctrl_q.running)
    else $error("running flag disagrees with phase");

  // a done beat reports the sequencer back at idle with valves closed
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && done_res_o) |->
      (phase_o == PH_IDLE) && !busy_res_o && !fill_valve_o && !drain_valve_o)
    else $error("done beat with sequencer not idle");

endmodule
